// ===== hw/rtl/gmtz_pkg.sv =====
// Shared types, constants and the min-plus step for the grid trailing-zero path block.
// Used by gmtz_factor and grid_min_trailing_zero_path; depends on nothing.
`default_nettype none

package gmtz_pkg;

  localparam int MaxNDefault = 1024;

  // Path sums are 16 bits; the all-ones code stands for "no open path".
  localparam logic [15:0] INF_MARK = 16'hFFFF;
  localparam logic [15:0] SAT_MAX  = 16'hFFFE;

  // Exact division by 5: for a multiple of 5, v * INV5 mod 2^32 is the quotient,
  // and a product at or below DIV5_LIMIT occurs only for multiples of 5.
  localparam logic [31:0] INV5       = 32'hCCCCCCCD;
  localparam logic [31:0] DIV5_LIMIT = 32'h33333333;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_UPDATE
  } state_t;

  // Status of the factor counter as seen by the top level.
  typedef struct packed {
    logic       done;
    logic       zero;
    logic [4:0] twos;
    logic [3:0] fives;
  } fac_stat_t;

  // One min-plus step: the cheaper neighbor plus the cell's own count,
  // with infinity absorbing and finite sums saturating below it.
  function automatic logic [15:0] advance(input logic [15:0] up, input logic [15:0] left,
                                          input logic [4:0] own);
    logic [15:0] m;
    logic [16:0] s;
    m = (up < left) ? up : left;
    s = {1'b0, m} + {12'd0, own};
    if (m == INF_MARK) begin
      return INF_MARK;
    end else if (s > {1'b0, SAT_MAX}) begin
      return SAT_MAX;
    end else begin
      return s[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/grid_min_trailing_zero_path.sv =====
// Least trailing-zero path over a square grid of cells, right and down moves only.
// Cells enter on the cell channel in row-major order, one beat per cell. After the
// last cell of a grid one beat leaves on the result channel: min_trailing and
// unreachable (set, with min_trailing 0, when zero cells block every path).
// cfg_we with cfg_wdata sets the grid side (0 acts as 1, above MAX_N as MAX_N) and
// restarts the grid at its first cell; write it only while the block is idle.
// Each cell runs through the factor count and the update before the next beat is taken,
// and k, the number of factors of 5 in the cell (0 to 13), sets how long the count runs:
// the factor counter strips one factor of 5 per cycle, a final count step runs while the
// line buffer is read, the update computes the sums and writes the line buffer back, and
// the idle state takes the next beat. result_valid is a register set by the last cell's
// update, and the result beat is taken while it is high and result_ready is high.
// The previous-row sums live in one RAM of MAX_N words; the left neighbor is a register.
// Reset returns to the first cell with a grid side of 1; the line buffer needs no
// clearing because a grid reads only entries it wrote itself.
// A stalled result beat holds in its register while the next grid streams in; only
// the update of a following grid's last cell waits for it to be taken.
`default_nettype none

module grid_min_trailing_zero_path import gmtz_pkg::*; #(
  parameter int MAX_N = MaxNDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [10:0]        cfg_wdata,
  input  wire logic               cell_valid,
  output logic                    cell_ready,
  input  wire logic signed [31:0] cell_value,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic      [15:0]        min_trailing,
  output logic                    unreachable
);

  localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CNT_W = $clog2(MAX_N + 1);
  localparam int SZ_W  = (CNT_W > 11) ? CNT_W : 11;

  state_t             state, state_next;
  fac_stat_t          fac;
  logic               start;
  logic               upd_go;
  logic [10:0]        grid_size;
  logic [SZ_W-1:0]    size_ext;
  logic [SZ_W-1:0]    eff_n;
  logic [IDX_W-1:0]   row_index, col_index;
  logic [15:0]        left_twos, left_fives;
  logic [31:0]        ram_rdata;
  logic [15:0]        up2, up5, lf2, lf5, c2, c5, cmin;
  logic               col_last, row_last, grid_last;
  logic [SZ_W-1:0]    col_inc;

  assign size_ext = {{(SZ_W - 11){1'b0}}, grid_size};

  always_comb begin
    if (size_ext == '0) begin
      eff_n = SZ_W'(1);
    end else if (size_ext > SZ_W'(MAX_N)) begin
      eff_n = SZ_W'(MAX_N);
    end else begin
      eff_n = size_ext;
    end
  end

  gmtz_factor u_factor (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cell_value (cell_value),
    .stat       (fac)
  );

  // Line buffer word: twos in the upper half, fives in the lower.
  gmtz_ram #(
    .WIDTH (32),
    .DEPTH (MAX_N)
  ) u_row_ram (
    .clk   (clk),
    .we    (upd_go),
    .waddr (col_index),
    .wdata ({c2, c5}),
    .raddr (col_index),
    .rdata (ram_rdata)
  );

  // Datapath of the update cycle.
  assign col_inc   = {{(SZ_W - IDX_W){1'b0}}, col_index} + SZ_W'(1);
  assign col_last  = (col_inc == eff_n);
  assign row_last  = ({{(SZ_W - IDX_W){1'b0}}, row_index} + SZ_W'(1) == eff_n);
  assign grid_last = col_last && row_last;

  assign up2 = (row_index == '0) ? INF_MARK : ram_rdata[31:16];
  assign up5 = (row_index == '0) ? INF_MARK : ram_rdata[15:0];
  assign lf2 = (col_index == '0) ? INF_MARK : left_twos;
  assign lf5 = (col_index == '0) ? INF_MARK : left_fives;

  always_comb begin
    if (fac.zero) begin
      c2 = INF_MARK;
      c5 = INF_MARK;
    end else if (row_index == '0 && col_index == '0) begin
      c2 = {11'd0, fac.twos};
      c5 = {12'd0, fac.fives};
    end else begin
      c2 = advance(up2, lf2, fac.twos);
      c5 = advance(up5, lf5, {1'b0, fac.fives});
    end
  end

  assign cmin = (c2 < c5) ? c2 : c5;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cell_valid) begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (fac.done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs. The last cell's update waits until the result register is free.
  always_comb begin
    cell_ready = 1'b0;
    upd_go     = 1'b0;
    unique case (state)
      ST_IDLE:   cell_ready = 1'b1;
      ST_COUNT:  cell_ready = 1'b0;
      ST_UPDATE: upd_go     = !grid_last || !result_valid || result_ready;
      default:   cell_ready = 1'b0;
    endcase
  end

  assign start = cell_valid && cell_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= 11'd1;
      row_index  <= '0;
      col_index  <= '0;
      left_twos  <= INF_MARK;
      left_fives <= INF_MARK;
    end else if (cfg_we) begin
      grid_size  <= cfg_wdata;
      row_index  <= '0;
      col_index  <= '0;
      left_twos  <= INF_MARK;
      left_fives <= INF_MARK;
    end else if (upd_go) begin
      if (grid_last) begin
        row_index  <= '0;
        col_index  <= '0;
        left_twos  <= INF_MARK;
        left_fives <= INF_MARK;
      end else if (col_last) begin
        row_index  <= row_index + IDX_W'(1);
        col_index  <= '0;
        left_twos  <= INF_MARK;
        left_fives <= INF_MARK;
      end else begin
        col_index  <= col_index + IDX_W'(1);
        left_twos  <= c2;
        left_fives <= c5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (upd_go && grid_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go && grid_last) begin
      if (cmin == INF_MARK) begin
        min_trailing <= 16'd0;
        unreachable  <= 1'b1;
      end else begin
        min_trailing <= cmin;
        unreachable  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gmtz_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the previous-row line buffer.
`default_nettype none

module gmtz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gmtz_factor.sv =====
// Counts the factors of 2 and of 5 of one grid cell.
// Twos come from a trailing-zero search; fives are stripped one per cycle. Uses gmtz_pkg.
`default_nettype none

module gmtz_factor import gmtz_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] cell_value,
  output fac_stat_t               stat
);

  logic        busy;
  logic        cnt_en;
  logic        zero;
  logic [31:0] val;
  logic [4:0]  twos;
  logic [3:0]  fives;
  logic [31:0] quot;
  logic        divisible;
  logic [4:0]  tz;
  logic        positive;

  assign positive  = (cell_value != 32'sd0) && !cell_value[31];
  assign quot      = val * INV5;
  assign divisible = cnt_en && (quot <= DIV5_LIMIT);

  // Lowest set bit wins, since the scan runs from the top down.
  always_comb begin
    tz = '0;
    for (int i = 31; i >= 0; i--) begin
      if (cell_value[i]) begin
        tz = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && !divisible) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val    <= cell_value;
      cnt_en <= positive;
      zero   <= (cell_value == 32'sd0);
      twos   <= positive ? tz : 5'd0;
      fives  <= '0;
    end else if (busy && divisible) begin
      val   <= quot;
      fives <= fives + 4'd1;
    end
  end

  assign stat.done  = busy && !divisible;
  assign stat.zero  = zero;
  assign stat.twos  = twos;
  assign stat.fives = fives;

endmodule

`default_nettype wire

// ===== tb/grid_min_trailing_zero_path_tb.sv =====
// Self-checking testbench for grid_min_trailing_zero_path: directed and random grids.
// A behavioral path-sum predictor checks every result beat. Depends on gmtz_pkg.
`default_nettype none

module grid_min_trailing_zero_path_tb;
  import gmtz_pkg::*;

  localparam int LINE_DEPTH = MaxNDefault;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_CELLS = 470;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint unsigned POS_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [15:0] trailing;
    logic        blocked;
  } path_result_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } ready_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic        [10:0] cfg_wdata = '0;
  logic               cell_valid = 1'b0;
  logic               cell_ready;
  logic signed [31:0] cell_value = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic        [15:0] min_trailing;
  logic               unreachable;

  always #2 clk = ~clk;

  grid_min_trailing_zero_path uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cell_valid  (cell_valid),
    .cell_ready  (cell_ready),
    .cell_value  (cell_value),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .min_trailing(min_trailing),
    .unreachable (unreachable)
  );

  // Predictor state: previous-row sums, west neighbor sums and grid position.
  logic [15:0]  line_twos [LINE_DEPTH];
  logic [15:0]  line_fives[LINE_DEPTH];
  logic [15:0]  west_twos = INF_MARK;
  logic [15:0]  west_fives = INF_MARK;
  int unsigned  cur_row = 0;
  int unsigned  cur_col = 0;
  logic [10:0]  side_setting = 11'd1;
  path_result_t expected_paths[$];

  int unsigned cells_sent = 0;
  int unsigned grids_checked = 0;
  int unsigned side_writes = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  bit          pace_on = 1'b1;
  int unsigned burst_left = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  ready_mode_t rx_mode = RX_STEADY;
  int unsigned rx_left = 0;

  function automatic int unsigned effective_side();
    if (side_setting == 11'd0) return 1;
    if (side_setting > 11'(LINE_DEPTH)) return LINE_DEPTH;
    return side_setting;
  endfunction

  function automatic void rewind_grid();
    cur_row = 0;
    cur_col = 0;
    west_twos = INF_MARK;
    west_fives = INF_MARK;
  endfunction

  function automatic int unsigned multiplicity(input logic [31:0] v, input int unsigned f);
    int unsigned n;
    logic [31:0] w;
    n = 0;
    w = v;
    while (w != 0 && (w % f) == 0) begin
      w = w / f;
      n++;
    end
    return n;
  endfunction

  // Cheaper neighbor plus own count; infinity absorbs, finite sums saturate.
  function automatic logic [15:0] extend_path(input logic [15:0] north, input logic [15:0] west,
                                              input int unsigned own);
    logic [15:0] m;
    int unsigned s;
    m = (north < west) ? north : west;
    if (m == INF_MARK) return INF_MARK;
    s = m + own;
    if (s > SAT_MAX) s = SAT_MAX;
    return 16'(s);
  endfunction

  function automatic void absorb_cell(input logic [31:0] raw);
    int unsigned  n, twos, fives;
    logic [15:0]  up2, up5, lf2, lf5, c2, c5, best;
    path_result_t res;
    n = effective_side();
    if (cur_col >= n || cur_row >= n) rewind_grid();
    twos = 0;
    fives = 0;
    if (raw != 0 && !raw[31]) begin
      twos = multiplicity(raw, 2);
      fives = multiplicity(raw, 5);
    end
    up2 = (cur_row == 0) ? INF_MARK : line_twos[cur_col];
    up5 = (cur_row == 0) ? INF_MARK : line_fives[cur_col];
    lf2 = (cur_col == 0) ? INF_MARK : west_twos;
    lf5 = (cur_col == 0) ? INF_MARK : west_fives;
    if (raw == 0) begin
      c2 = INF_MARK;
      c5 = INF_MARK;
    end else if (cur_row == 0 && cur_col == 0) begin
      c2 = 16'(twos);
      c5 = 16'(fives);
    end else begin
      c2 = extend_path(up2, lf2, twos);
      c5 = extend_path(up5, lf5, fives);
    end
    line_twos[cur_col] = c2;
    line_fives[cur_col] = c5;
    west_twos = c2;
    west_fives = c5;
    if (cur_row == n - 1 && cur_col == n - 1) begin
      best = (c2 < c5) ? c2 : c5;
      res.blocked = (best == INF_MARK);
      res.trailing = res.blocked ? 16'd0 : best;
      expected_paths.push_back(res);
      rewind_grid();
    end else begin
      cur_col++;
      if (cur_col >= n) begin
        cur_col = 0;
        cur_row++;
        west_twos = INF_MARK;
        west_fives = INF_MARK;
      end
    end
  endfunction

  // Positive values are mostly built from chosen powers of 2 and 5 so that the
  // path sums stay interesting; the rest are zeros, negatives and raw words.
  function automatic logic [31:0] random_cell(input int unsigned zero_pct);
    longint unsigned acc;
    int unsigned     fives, twos, mul, kind;
    if ($urandom_range(0, 99) < zero_pct) return '0;
    kind = $urandom_range(0, 99);
    if (kind < 12) return $urandom() | 32'h8000_0000;
    if (kind < 25) return $urandom();
    acc = 1;
    fives = $urandom_range(0, 13);
    twos = $urandom_range(0, 30);
    repeat (fives) if (acc * 5 <= POS_MAX) acc = acc * 5;
    repeat (twos) if (acc * 2 <= POS_MAX) acc = acc * 2;
    mul = $urandom_range(1, 999);
    if (acc * mul <= POS_MAX) acc = acc * mul;
    return acc[31:0];
  endfunction

  // Called just after a rising edge; returns at the edge where the beat was taken.
  task automatic send_cell(input logic [31:0] v);
    int unsigned gap;
    gap = 0;
    if (pace_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    if (gap != 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_value <= v;
    do @(posedge clk); while (!cell_ready);
    absorb_cell(v);
    cells_sent++;
  endtask

  // Lets every expected beat arrive and the last cell finish before a size write.
  task automatic wait_idle();
    cell_valid <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid_side(input logic [10:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    side_setting = v;
    rewind_grid();
    side_writes++;
  endtask

  task automatic test_reset_side();
    logic [31:0] cells[11] = '{32'd0, 32'd1, 32'd1000, -32'sd1000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h4000_0000, 32'd1220703125,
                               32'd1000000000, 32'hFFFF_FFFF, 32'd500000000};
    foreach (cells[i]) send_cell(cells[i]);
  endtask

  task automatic test_blocking_cases();
    logic [31:0] two_by_two[16] = '{32'd0, 32'd10, 32'd10, 32'd10,
                                   32'd10, 32'd0, 32'd0, 32'd10,
                                   32'd10, 32'd0, 32'd20, 32'd10,
                                   -32'sd4, 32'd25, 32'd8, -32'sd1};
    logic [31:0] wall[9] = '{32'd8, 32'd8, 32'd0, 32'd8, 32'd0, 32'd8, 32'd0, 32'd8, 32'd8};
    wait_idle();
    set_grid_side(11'd0);
    send_cell(32'd1000);
    wait_idle();
    set_grid_side(11'd2);
    foreach (two_by_two[i]) send_cell(two_by_two[i]);
    wait_idle();
    set_grid_side(11'd3);
    foreach (wall[i]) send_cell(wall[i]);
  endtask

  // A size write drops a partial grid and starts over at the first cell.
  task automatic test_partial_grids();
    wait_idle();
    set_grid_side(11'd3);
    repeat (4) send_cell(random_cell(0));
    wait_idle();
    set_grid_side(11'd2);
    repeat (4) send_cell(random_cell(0));
  endtask

  // The largest side and a side beyond it, clamped to the line depth, both left partial.
  task automatic test_full_width_line();
    wait_idle();
    set_grid_side(11'd1024);
    repeat (40) send_cell(random_cell(0));
    wait_idle();
    set_grid_side(11'd2047);
    repeat (3) send_cell(random_cell(5));
    wait_idle();
  endtask

  task automatic test_random_grids();
    int unsigned made, n, cnt, zero_pct, pick;
    bit          need_side;
    made = 0;
    need_side = 1'b1;
    while (made < RANDOM_CELLS) begin
      if (need_side || $urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 99);
        wait_idle();
        if (pick < 70) set_grid_side(11'($urandom_range(1, 4)));
        else if (pick < 88) set_grid_side(11'($urandom_range(5, 10)));
        else if (pick < 93) set_grid_side(11'd0);
        else if (pick < 97) set_grid_side(11'($urandom_range(11, 16)));
        else set_grid_side($urandom_range(0, 1) ? 11'd1024 : 11'($urandom_range(1025, 2047)));
        need_side = 1'b0;
      end
      n = effective_side();
      case ($urandom_range(0, 3))
        0: zero_pct = 0;
        1: zero_pct = 4;
        2: zero_pct = 12;
        default: zero_pct = 35;
      endcase
      pace_on = ($urandom_range(0, 3) != 0);
      cnt = n * n;
      if (n > 16) begin
        cnt = $urandom_range(1, 40);
        need_side = 1'b1;
      end else if (n > 1 && $urandom_range(0, 9) == 0) begin
        cnt = $urandom_range(1, n * n - 1);
        need_side = 1'b1;
      end
      repeat (cnt) send_cell(random_cell(zero_pct));
      made += cnt;
    end
    pace_on = 1'b1;
    wait_idle();
  endtask

  // The receiver stalls for a long stretch while single-cell grids keep coming,
  // so the held result beat backs up into the cell channel.
  task automatic test_result_backpressure();
    wait_idle();
    set_grid_side(11'd1);
    pace_on = 1'b0;
    hold_asks <= hold_asks + 1;
    repeat (40) send_cell(random_cell(10));
    pace_on = 1'b1;
    wait_idle();
  endtask

  task automatic check_beat();
    path_result_t want;
    if (expected_paths.size() == 0) begin
      $error("unexpected result beat: min_trailing %0d, unreachable %0d",
             min_trailing, unreachable);
      failures++;
    end else begin
      want = expected_paths.pop_front();
      if (min_trailing !== want.trailing) begin
        $error("min_trailing: expected %0d, actual %0d", want.trailing, min_trailing);
        failures++;
      end
      if (unreachable !== want.blocked) begin
        $error("unreachable: expected %0d, actual %0d", want.blocked, unreachable);
        failures++;
      end
      grids_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) check_beat();
      if (hold_asks != hold_taken) begin
        hold_taken = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = ready_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(20, 200);
        end else begin
          rx_left--;
        end
        case (rx_mode)
          RX_STEADY: result_ready <= 1'b1;
          RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: result_ready <= ($urandom_range(0, 4) == 0);
          default:   result_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[grid_min_trailing_zero_path] ERROR");
      $finish;
    end
  end

  initial begin
    rewind_grid();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_side();
    test_blocking_cases();
    test_partial_grids();
    test_full_width_line();
    test_random_grids();
    test_result_backpressure();
    wait_idle();
    $display("Sent %0d cells and checked %0d grid results across %0d grid-side writes,",
             cells_sent, grids_checked, side_writes);
    $display("including blocked grids, negative cells, the largest grid side and a long stall.");
    if (failures == 0) begin
      $display("[grid_min_trailing_zero_path] OK");
    end else begin
      $display("[grid_min_trailing_zero_path] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
